// ----- src/afs_pkg.sv -----
// Shared types and constants for the animation frame sequencer.
`default_nettype none
package afs_pkg;

  // Field widths of the channels and registers.
  localparam int ELAPSED_W   = 16;
  localparam int FRAME_X_W   = 20;
  localparam int FRAME_NUM_W = 8;
  localparam int WIDTH_W     = 12;
  localparam int PERIOD_W    = 16;
  localparam int LAST_W      = 8;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_FRAME  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE   = 2'd3;

  // Playback modes. The fourth code plays once, like MODE_ONCE.
  localparam logic [MODE_W-1:0] MODE_ONCE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PING = 2'd2;

  typedef struct packed {
    logic [WIDTH_W-1:0]  frame_width;
    logic [PERIOD_W-1:0] frame_period_ms;
    logic [LAST_W-1:0]   last_frame_index;
    logic [MODE_W-1:0]   loop_mode;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MOD_LOAD,
    ST_MOD,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic load_mod;
    logic update;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic iter_done;
    logic need_mod;
    logic out_full;
  } sts_t;

endpackage
`default_nettype wire

// ----- src/afs_if.sv -----
// Stream interfaces for the request and result channels.
`default_nettype none
interface afs_in_if;
  import afs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed_ms;

  modport source (output valid, output elapsed_ms, input ready);
  modport sink   (input valid, input elapsed_ms, output ready);
endinterface

interface afs_out_if;
  import afs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [FRAME_X_W-1:0]   frame_x;
  logic [FRAME_NUM_W-1:0] frame_number;
  logic                   going_forward;

  modport source (output valid, output frame_x, output frame_number,
                  output going_forward, input ready);
  modport sink   (input valid, input frame_x, input frame_number,
                  input going_forward, output ready);
endinterface
`default_nettype wire

// ----- src/afs_cfg.sv -----
// Configuration register file with write decode.
`default_nettype none
module afs_cfg (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [afs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [afs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output afs_pkg::cfg_t                    cfg
);
  import afs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH: cfg_nxt.frame_width      = cfg_wdata[WIDTH_W-1:0];
        CFG_PERIOD_MS:   cfg_nxt.frame_period_ms  = cfg_wdata[PERIOD_W-1:0];
        CFG_LAST_FRAME:  cfg_nxt.last_frame_index = cfg_wdata[LAST_W-1:0];
        CFG_LOOP_MODE:   cfg_nxt.loop_mode        = cfg_wdata[MODE_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width      <= WIDTH_W'(32);
      cfg_r.frame_period_ms  <= PERIOD_W'(100);
      cfg_r.last_frame_index <= '0;
      cfg_r.loop_mode        <= MODE_ONCE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- src/afs_ctrl.sv -----
// Controller state machine that sequences the divider passes and the result.
`default_nettype none
module afs_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  wire afs_pkg::sts_t sts,
  output afs_pkg::cmd_t  cmd
);
  import afs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.iter_done) begin
          state_nxt = sts.need_mod ? ST_MOD_LOAD : ST_UPDATE;
        end
      end
      ST_MOD_LOAD: begin
        cmd.load_mod = 1'b1;
        state_nxt    = ST_MOD;
      end
      ST_MOD: begin
        cmd.step = 1'b1;
        if (sts.iter_done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold here until the output register can take the new beat.
        if (!sts.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/afs_dpath.sv -----
// Datapath: serial divider, frame state update and output register.
`default_nettype none
module afs_dpath #(
  parameter int FRAME_INDEX_BITS = 8
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire afs_pkg::cfg_t                 cfg,
  input  wire afs_pkg::cmd_t                 cmd,
  output afs_pkg::sts_t                      sts,
  input  wire  [afs_pkg::ELAPSED_W-1:0]      elapsed_ms,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [afs_pkg::FRAME_X_W-1:0]      frame_x,
  output logic [afs_pkg::FRAME_NUM_W-1:0]    frame_number,
  output logic                               going_forward
);
  import afs_pkg::*;

  // Dividend width covers leftover plus elapsed, and frame plus steps.
  localparam int DW = ((FRAME_INDEX_BITS > ELAPSED_W + 1) ?
                       FRAME_INDEX_BITS : ELAPSED_W + 1) + 1;
  localparam int CW = $clog2(DW);
  localparam int PW = FRAME_INDEX_BITS + WIDTH_W;
  localparam int XW = (PW > FRAME_X_W) ? PW : FRAME_X_W;

  // Divider registers: quo_r shifts the dividend out and the quotient in.
  logic [DW-1:0]       quo_r, quo_nxt;
  logic [PERIOD_W-1:0] rem_r, rem_nxt;
  logic [PERIOD_W-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [PERIOD_W-1:0] rest_r, rest_nxt;

  // Sequencer state and output register.
  logic [FRAME_INDEX_BITS-1:0] frame_now_r, frame_now_nxt;
  logic [PERIOD_W-1:0]         leftover_r, leftover_nxt;
  logic                        forward_r, forward_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [FRAME_X_W-1:0]        frame_x_r, frame_x_nxt;
  logic [FRAME_NUM_W-1:0]      frame_num_r, frame_num_nxt;
  logic                        going_fwd_r, going_fwd_nxt;

  logic [PERIOD_W:0]   shifted;
  logic [PERIOD_W:0]   diff;
  logic [DW-1:0]       f_ext;
  logic [DW-1:0]       last_ext;
  logic [DW-1:0]       last2;
  logic [DW-1:0]       fwd_sum;
  logic [DW-1:0]       back_gap;
  logic [DW-1:0]       f_new;
  logic [XW-1:0]       product;

  assign shifted  = {rem_r, quo_r[DW-1]};
  assign diff     = shifted - {1'b0, dvs_r};
  assign f_ext    = DW'(frame_now_r);
  assign last_ext = DW'(cfg.last_frame_index);
  assign last2    = last_ext << 1;
  assign fwd_sum  = f_ext + quo_r;
  assign back_gap = quo_r - f_ext;
  assign product  = XW'(frame_now_r) * XW'(cfg.frame_width);

  // Divider control.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    rest_nxt = rest_r;
    if (cmd.load) begin
      quo_nxt = DW'(leftover_r) + DW'(elapsed_ms);
      rem_nxt = '0;
      // A zero period counts as one millisecond.
      dvs_nxt = (cfg.frame_period_ms == '0) ? PERIOD_W'(1) : cfg.frame_period_ms;
      cnt_nxt = '0;
    end else if (cmd.load_mod) begin
      quo_nxt  = fwd_sum;
      rem_nxt  = '0;
      dvs_nxt  = PERIOD_W'(cfg.last_frame_index) + PERIOD_W'(1);
      cnt_nxt  = '0;
      rest_nxt = rem_r;
    end else if (cmd.step) begin
      if (!diff[PERIOD_W]) begin
        rem_nxt = diff[PERIOD_W-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[PERIOD_W-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  // Frame update; quo_r holds the step count, rem_r the new leftover time (loop mode: the frame, rest_r the leftover).
  always_comb begin
    f_new        = f_ext;
    leftover_nxt = leftover_r;
    forward_nxt  = forward_r;
    unique case (cfg.loop_mode)
      MODE_LOOP: begin
        f_new        = DW'(rem_r);
        leftover_nxt = rest_r;
      end
      MODE_PING: begin
        leftover_nxt = rem_r;
        if (forward_r) begin
          if (fwd_sum > last_ext) begin
            f_new       = (fwd_sum > last2) ? '0 : last2 - fwd_sum;
            forward_nxt = 1'b0;
          end else begin
            f_new = fwd_sum;
          end
        end else begin
          if (f_ext >= quo_r) begin
            f_new = f_ext - quo_r;
          end else begin
            f_new       = (back_gap > last_ext) ? last_ext : back_gap;
            forward_nxt = 1'b1;
          end
        end
      end
      default: begin
        // Play once: nothing moves while the last frame is showing.
        if (f_ext != last_ext) begin
          f_new        = (fwd_sum > last_ext) ? last_ext : fwd_sum;
          leftover_nxt = rem_r;
        end
      end
    endcase
  end

  always_comb begin
    frame_now_nxt = frame_now_r;
    if (cmd.update) begin
      frame_now_nxt = f_new[FRAME_INDEX_BITS-1:0];
    end
    out_valid_nxt = out_valid_r && !out_ready;
    frame_x_nxt   = frame_x_r;
    frame_num_nxt = frame_num_r;
    going_fwd_nxt = going_fwd_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      frame_x_nxt   = product[FRAME_X_W-1:0];
      frame_num_nxt = FRAME_NUM_W'(frame_now_r);
      going_fwd_nxt = forward_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_now_r <= '0;
      leftover_r  <= '0;
      forward_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      frame_now_r <= frame_now_nxt;
      if (cmd.update) begin
        leftover_r <= leftover_nxt;
        forward_r  <= forward_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    dvs_r       <= dvs_nxt;
    cnt_r       <= cnt_nxt;
    rest_r      <= rest_nxt;
    frame_x_r   <= frame_x_nxt;
    frame_num_r <= frame_num_nxt;
    going_fwd_r <= going_fwd_nxt;
  end

  assign sts.iter_done = (cnt_r == CW'(DW - 1));
  assign sts.need_mod  = (cfg.loop_mode == MODE_LOOP);
  assign sts.out_full  = out_valid_r && !out_ready;

  assign out_valid     = out_valid_r;
  assign frame_x       = frame_x_r;
  assign frame_number  = frame_num_r;
  assign going_forward = going_fwd_r;

endmodule
`default_nettype wire

// ----- src/animation_frame_sequencer_top.sv -----
// Top level of the animation frame sequencer.
//
//  Channel  Direction  Handshake          Beat payload
//  in_ch    sink       valid/ready        elapsed_ms[15:0]
//  out_ch   source     valid/ready        frame_x[19:0], frame_number[7:0], going_forward
//  cfg_*    sink       cfg_we (no wait)   cfg_index[1:0], cfg_wdata[15:0]
//
// One request at a time: an 18-step restoring divider forms the step count, and in
// loop mode a second pass forms the wrap modulo; then the frame state updates and
// the result enters the output register, after which the next request beat is taken.
// Reset is synchronous and active low; it restores register defaults and the
// frame state. A result waits in the output register while the next request
// is taken; the following result waits for that register to drain.
`default_nettype none
module animation_frame_sequencer_top #(
  parameter int FRAME_INDEX_BITS = 8
) (
  input  wire                             clk,
  input  wire                             rst_n,
  afs_in_if.sink                          in_ch,
  afs_out_if.source                       out_ch,
  input  wire                             cfg_we,
  input  wire  [afs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [afs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import afs_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  afs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  afs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  afs_dpath #(
    .FRAME_INDEX_BITS (FRAME_INDEX_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .elapsed_ms    (in_ch.elapsed_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ch.ready),
    .frame_x       (out_ch.frame_x),
    .frame_number  (out_ch.frame_number),
    .going_forward (out_ch.going_forward)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

`ifndef NO_ASSERTIONS
  // Only one datapath command is issued in any cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.load_mod, cmd.update, cmd.emit}))
    else $error("more than one datapath command in a cycle");

  // A request beat closes the input until its result is emitted.
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("input reopened right after a request beat");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid && !out_ch.ready))
    else $error("result emitted over a pending beat");

  // The state update is always followed by the emit stage.
  a_update_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> !in_ready)
    else $error("input opened before the result was emitted");
`endif

endmodule
`default_nettype wire
